// File: rtl/asoa_pkg.sv
// Shared types, constants and helpers for the ADC scan oversample average block.
package asoa_pkg;

  localparam int unsigned SAMPLE_SHIFT_DEF = 4;
  localparam int unsigned SLOTS_DEF        = 8;

  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned RSLOT_W     = 3;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned TABLE_CODES = 8;
  localparam int unsigned TABLE_W     = CODE_W * TABLE_CODES;
  localparam int unsigned CH_W        = 4;
  localparam int unsigned SLOT_IDX_W  = 4;   // covers the largest slot count
  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned APB_ADDR_W  = 4;

  // Register index, taken from paddr[3] (8-byte stride)
  localparam logic REG_CHANNELS  = 1'b0;
  localparam logic REG_MUX_TABLE = 1'b1;

  typedef enum logic {
    MODE_CONVERT = 1'b0,
    MODE_READ    = 1'b1
  } mode_e;

  typedef struct packed {
    logic [CH_W-1:0]    channels_in_use;
    logic [TABLE_W-1:0] mux_table;
  } cfg_t;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample_value;
    logic [RSLOT_W-1:0]  read_slot;
    logic                converter_busy;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] read_value;
    logic                start_conversion;
    logic                average_stored;
    logic [CODE_W-1:0]   mux_select;
  } out_item_t;

  // Mux code of a slot; slots without a table entry give zero.
  function automatic logic [CODE_W-1:0] mux_code(input logic [TABLE_W-1:0]    tbl,
                                                input logic [SLOT_IDX_W-1:0] slot);
    logic [CODE_W-1:0] code;
    code = '0;
    if (!slot[SLOT_IDX_W-1]) begin
      code = tbl[slot[SLOT_IDX_W-2:0] * CODE_W +: CODE_W];
    end
    return code;
  endfunction

endpackage

// File: rtl/asoa_in_if.sv
// Input channel: conversion or read transaction.
interface asoa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [asoa_pkg::SAMPLE_W-1:0] sample_value;
  logic [asoa_pkg::RSLOT_W-1:0]  read_slot;
  logic                          converter_busy;

  modport source (output valid, mode, sample_value, read_slot, converter_busy, input ready);
  modport sink   (input valid, mode, sample_value, read_slot, converter_busy, output ready);
endinterface

// File: rtl/asoa_out_if.sv
// Output channel: one result transaction per input transaction.
interface asoa_out_if;
  logic                          valid;
  logic                          ready;
  logic [asoa_pkg::SAMPLE_W-1:0] read_value;
  logic                          start_conversion;
  logic                          average_stored;
  logic [asoa_pkg::CODE_W-1:0]   mux_select;

  modport source (output valid, read_value, start_conversion, average_stored, mux_select,
                  input ready);
  modport sink   (input valid, read_value, start_conversion, average_stored, mux_select,
                  output ready);
endinterface

// File: rtl/asoa_cfg_regs.sv
// APB configuration registers: channel count and packed mux code table.
module asoa_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [asoa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [asoa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [asoa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output asoa_pkg::cfg_t                      cfg_o
);
  import asoa_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channels_in_use <= CH_W'(1);
      cfg_q.mux_table       <= '0;
    end else if (wr_en) begin
      case (paddr[3])
        REG_CHANNELS:  cfg_q.channels_in_use <= pwdata[CH_W-1:0];
        REG_MUX_TABLE: cfg_q.mux_table       <= pwdata[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_CHANNELS:  prdata = APB_DATA_W'(cfg_q.channels_in_use);
      REG_MUX_TABLE: prdata = APB_DATA_W'(cfg_q.mux_table);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// File: rtl/asoa_core.sv
// Scan state (accumulator, count, slot, averages) and per-transaction result logic.
module asoa_core #(
  parameter int unsigned SAMPLE_SHIFT = asoa_pkg::SAMPLE_SHIFT_DEF,
  parameter int unsigned SLOTS        = asoa_pkg::SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  asoa_pkg::in_item_t  item_i,
  input  asoa_pkg::cfg_t      cfg_i,
  output asoa_pkg::out_item_t result_o
);
  import asoa_pkg::*;

  localparam int unsigned ACC_W  = SAMPLE_W + SAMPLE_SHIFT;
  localparam int unsigned CNT_W  = SAMPLE_SHIFT + 1;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LIM_W  = CH_W + 1;

  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SAMPLE_W-1:0] avg_q [SLOTS];

  logic [LIM_W-1:0]    limit;
  logic [LIM_W-1:0]    slot_inc;
  logic [LIM_W-1:0]    rslot_ext;
  logic                rslot_ok;
  logic                is_read;
  logic                store;
  logic [SAMPLE_W-1:0] avg_new;

  assign is_read = (item_i.mode == MODE_READ);
  // count reaches 2^SHIFT exactly when its top bit sets
  assign store   = !is_read && cnt_q[CNT_W-1];
  assign avg_new = acc_q[ACC_W-1 -: SAMPLE_W];

  // zero channels acts as one, more than SLOTS acts as SLOTS
  always_comb begin
    if (cfg_i.channels_in_use == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(cfg_i.channels_in_use) > LIM_W'(SLOTS)) begin
      limit = LIM_W'(SLOTS);
    end else begin
      limit = LIM_W'(cfg_i.channels_in_use);
    end
  end

  assign slot_inc = LIM_W'(slot_q) + LIM_W'(1);

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (!is_read) begin
      if (store) begin
        acc_d  = '0;
        cnt_d  = '0;
        slot_d = (slot_inc < limit) ? slot_inc[SLOT_W-1:0] : '0;
      end else begin
        acc_d = acc_q + ACC_W'(item_i.sample_value);
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      slot_q <= '0;
    end else if (fire_i) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        avg_q[i] <= '0;
      end
    end else if (fire_i && store) begin
      avg_q[slot_q] <= avg_new;
    end
  end

  assign rslot_ext = LIM_W'(item_i.read_slot);
  assign rslot_ok  = rslot_ext < LIM_W'(SLOTS);

  always_comb begin
    result_o.read_value       = '0;
    result_o.start_conversion = 1'b0;
    result_o.average_stored   = store;
    if (is_read) begin
      result_o.read_value       = rslot_ok ? avg_q[rslot_ext[SLOT_W-1:0]] : '0;
      result_o.start_conversion = !item_i.converter_busy;
    end
    result_o.mux_select = mux_code(cfg_i.mux_table, SLOT_IDX_W'(slot_d));
  end
endmodule

// File: rtl/adc_scan_oversample_average_top.sv
// Top level of the ADC round-robin scan with oversampling average.
//
//   channel  | dir | payload                                              | handshake
//   ---------+-----+------------------------------------------------------+----------------
//   in_ch    | in  | mode, sample_value, read_slot, converter_busy        | valid/ready
//   out_ch   | out | read_value, start_conversion, average_stored,        | valid/ready
//            |     | mux_select                                           |
//   APB      | in  | channels_in_use @0x0, mux_table @0x8 (64-bit data)    | psel/penable
//
// One transaction per cycle sustained while out_ch is ready; a result is presented on out_ch
// after its transaction passes the input register, then the result register.
// The accumulate/store update in asoa_core never holds the flow of transactions.
// Reset clears the scan state, all slot averages and the pipeline valid flags.
// A stalled output holds its result; one further transaction is taken into the
// input register, after which in_ch.ready drops until the output drains.
module adc_scan_oversample_average_top #(
  parameter int unsigned SAMPLE_SHIFT = asoa_pkg::SAMPLE_SHIFT_DEF,
  parameter int unsigned SLOTS        = asoa_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  asoa_in_if.sink                         in_ch,
  asoa_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [asoa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [asoa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [asoa_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import asoa_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res;
  out_item_t out_q;
  logic      out_vld_q;
  logic      advance;   // result register free to take the next result
  logic      fire;      // input register transaction is processed this cycle
  logic      in_take;

  asoa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance     = !out_vld_q || out_ch.ready;
  assign fire        = in_vld_q && advance;
  assign in_ch.ready = !in_vld_q || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.mode           <= in_ch.mode;
      in_q.sample_value   <= in_ch.sample_value;
      in_q.read_slot      <= in_ch.read_slot;
      in_q.converter_busy <= in_ch.converter_busy;
    end
  end

  asoa_core #(
    .SAMPLE_SHIFT (SAMPLE_SHIFT),
    .SLOTS        (SLOTS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_ch.valid            = out_vld_q;
  assign out_ch.read_value       = out_q.read_value;
  assign out_ch.start_conversion = out_q.start_conversion;
  assign out_ch.average_stored   = out_q.average_stored;
  assign out_ch.mux_select       = out_q.mux_select;
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the ADC scan oversample average block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import asoa_pkg::*;

  localparam int unsigned SHIFT       = SAMPLE_SHIFT_DEF;
  localparam int unsigned NUM_SLOTS   = SLOTS_DEF;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with work pending and no transaction
  localparam int unsigned NUM_PHASES  = 8;

  // Receiver back-pressure styles, switched at random intervals
  typedef enum logic [1:0] {
    RX_OPEN,      // always ready
    RX_COIN,      // ready half of the time
    RX_PERIODIC,  // stalls a quarter of the time, periodically
    RX_RARE       // ready seven eighths of the time, at random
  } rx_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  asoa_in_if  in_ch ();
  asoa_out_if out_ch ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  adc_scan_oversample_average_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Transactions waiting to be sent, and results expected back in order
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  // Shadow of the block: configuration and scan state
  logic [CH_W-1:0]    chan_shadow;
  logic [TABLE_W-1:0] mux_shadow;
  int unsigned        acc_sum;
  int unsigned        n_summed;
  int unsigned        scan_slot;
  logic [SAMPLE_W-1:0] avg_mem [NUM_SLOTS];

  int unsigned err_cnt    = 0;
  int unsigned n_conv     = 0;
  int unsigned n_read     = 0;
  int unsigned n_stored   = 0;
  int unsigned n_writes   = 0;
  int unsigned n_settings = 0;

  // Next result of the scan for one accepted transaction; updates the shadow state.
  function automatic out_item_t scan_predict(input in_item_t it);
    out_item_t   res;
    int unsigned lim;
    res = '0;
    if (mode_e'(it.mode) == MODE_CONVERT) begin
      if (n_summed < (1 << SHIFT)) begin
        n_summed++;
        acc_sum += it.sample_value;
      end else begin
        // full set summed: this sample is dropped, the average is stored
        if (scan_slot < NUM_SLOTS) avg_mem[scan_slot] = SAMPLE_W'(acc_sum >> SHIFT);
        acc_sum  = 0;
        n_summed = 0;
        lim = (chan_shadow == 0) ? 1 : (chan_shadow > NUM_SLOTS) ? NUM_SLOTS : chan_shadow;
        // a slot left beyond a shrunken count still stores, then wraps to zero
        scan_slot = (scan_slot + 1 < lim) ? scan_slot + 1 : 0;
        res.average_stored = 1'b1;
      end
    end else begin
      if (it.read_slot < NUM_SLOTS) res.read_value = avg_mem[it.read_slot];
      res.start_conversion = !it.converter_busy;
    end
    res.mux_select = (scan_slot < TABLE_CODES) ? mux_shadow[scan_slot*CODE_W +: CODE_W] : '0;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // APB write: setup cycle, then access cycle until pready; shadow follows the write.
  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CHANNELS) chan_shadow = data[CH_W-1:0];
    else                     mux_shadow  = data[TABLE_W-1:0];
    n_writes++;
  endtask

  // Block is idle once nothing is queued and every result is back.
  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_item(input mode_e mode, input logic [SAMPLE_W-1:0] sample,
                            input logic [RSLOT_W-1:0] slot, input logic busy);
    in_item_t it;
    it.mode           = mode;
    it.sample_value   = sample;
    it.read_slot      = slot;
    it.converter_busy = busy;
    pending_items.push_back(it);
  endtask

  // Mostly conversions so that averages keep completing; reads sprinkled in.
  // Unused fields carry random junk, samples lean toward the extremes.
  task automatic queue_random_item();
    logic [SAMPLE_W-1:0] sample;
    case ($urandom_range(0, 7))
      0:       sample = '0;
      1:       sample = '1;
      default: sample = SAMPLE_W'($urandom_range(0, 1023));
    endcase
    queue_item(($urandom_range(0, 4) == 0) ? MODE_READ : MODE_CONVERT, sample,
               RSLOT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends bursts of random length separated by random gaps. A
  // presented transaction holds until accepted; the shadow is stepped at the
  // acceptance edge so prediction always sees the config in force.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        if (mode_e'(pending_items[0].mode) == MODE_CONVERT) n_conv++;
        else                                                n_read++;
        expected_results.push_back(scan_predict(pending_items[0]));
        void'(pending_items.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_ch.valid          <= 1'b1;
          in_ch.mode           <= pending_items[0].mode;
          in_ch.sample_value   <= pending_items[0].sample_value;
          in_ch.read_slot      <= pending_items[0].read_slot;
          in_ch.converter_busy <= pending_items[0].converter_busy;
          burst_left--;
          if (burst_left == 0) begin
            // about a quarter of bursts run straight into the next one
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: the style changes at random intervals so stalls
  // land on every phase of the accumulate/store cycle.
  // ---------------------------------------------------------------------------
  rx_style_e   rx_style = RX_OPEN;
  int unsigned rx_tick  = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_tick == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
        rx_tick  = $urandom_range(50, 200);
      end else begin
        rx_tick--;
      end
      case (rx_style)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ch.ready <= (rx_tick % 4) != 0;
        default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result transaction is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected result, expected none, actual %0d/%0b/%0b/%0d",
                 $time, out_ch.read_value, out_ch.start_conversion, out_ch.average_stored,
                 out_ch.mux_select);
      end else begin
        want = expected_results.pop_front();
        check_field("read_value", want.read_value, out_ch.read_value);
        check_field("start_conversion", want.start_conversion, out_ch.start_conversion);
        check_field("average_stored", want.average_stored, out_ch.average_stored);
        check_field("mux_select", want.mux_select, out_ch.mux_select);
        if (out_ch.average_stored) n_stored++;
      end
    end
  end

  // Watchdog: only counts while work is outstanding.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_items.size() == 0 && expected_results.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_results.size());
        $display("adc_scan_oversample_average_top verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Registers are only touched when the block has drained.
  // ---------------------------------------------------------------------------
  int unsigned phase_ch  [NUM_PHASES] = '{8, 2, 0, 15, 1, 5, 8, 0};
  int unsigned phase_len [NUM_PHASES] = '{120, 60, 60, 80, 60, 70, 80, 70};

  initial begin
    logic [APB_DATA_W-1:0] tbl_word;
    logic [APB_DATA_W-1:0] ch_word;

    // known values on every input from time zero
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_CONVERT;
    in_ch.sample_value   = '0;
    in_ch.read_slot      = '0;
    in_ch.converter_busy = 1'b0;
    out_ch.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;

    chan_shadow = CH_W'(1);
    mux_shadow  = '0;
    acc_sum     = 0;
    n_summed    = 0;
    scan_slot   = 0;
    foreach (avg_mem[k]) avg_mem[k] = '0;
    phase_ch[NUM_PHASES-1] = $urandom_range(0, 15);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: averages read zero, mux code zero. Idle converter asks
    // for a start, a busy one does not; sample field is ignored on reads.
    queue_item(MODE_READ, '0, 3'd3, 1'b0);
    queue_item(MODE_READ, '1, 3'd7, 1'b1);
    wait_idle();

    // Two slots; slot 0 code all ones, slot 1 code zero
    write_reg(REG_CHANNELS, 64'd2);
    write_reg(REG_MUX_TABLE, 64'h0000_0055_5555_541F);
    n_settings++;

    // Full-scale set into slot 0. The first conversion carries junk in the
    // read fields; the seventeenth sample is dropped and the slot steps.
    queue_item(MODE_CONVERT, '1, 3'd7, 1'b1);
    repeat ((1 << SHIFT) - 1) queue_item(MODE_CONVERT, '1, 3'd0, 1'b0);
    queue_item(MODE_CONVERT, '0, 3'd0, 1'b0);
    queue_item(MODE_READ, '0, 3'd0, 1'b0);
    queue_item(MODE_READ, '0, 3'd0, 1'b1);
    queue_item(MODE_READ, '1, 3'd1, 1'b0);
    wait_idle();

    // Random phases. Each ends with the sender held until every result is back.
    // The long eight-slot phase leaves the scan deep in the table so the
    // following two-slot setting exercises a slot beyond the count.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 3)
        0:       tbl_word = {$urandom(), $urandom()} | 64'h0000_00FF_FFFF_FFFF;
        1:       tbl_word = {$urandom(), $urandom()} & 64'hFFFF_FF00_0000_0000;
        default: tbl_word = {$urandom(), $urandom()};
      endcase
      ch_word = {$urandom(), $urandom()};
      ch_word[CH_W-1:0] = CH_W'(phase_ch[ph]);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_CHANNELS, ch_word);
        write_reg(REG_MUX_TABLE, tbl_word);
      end else begin
        write_reg(REG_MUX_TABLE, tbl_word);
        write_reg(REG_CHANNELS, ch_word);
      end
      n_settings++;
      repeat (phase_len[ph]) queue_random_item();
      wait_idle();
    end

    $display("Sent %0d conversion and %0d read transactions over %0d register settings",
             n_conv, n_read, n_settings);
    $display("%0d averages stored, %0d register writes, %0d mismatches",
             n_stored, n_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("adc_scan_oversample_average_top verification clean");
    end else begin
      $display("adc_scan_oversample_average_top verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/asoa_pkg.sv
rtl/asoa_in_if.sv
rtl/asoa_out_if.sv
rtl/asoa_cfg_regs.sv
rtl/asoa_core.sv
rtl/adc_scan_oversample_average_top.sv
tb/testbench.sv
